[rtl/core/bqls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_pkg
// Types and fixed widths shared by the low-shelf biquad modules.
// ----------------------------------------------------------------------------
package bqls_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int FB_W       = 32;
   localparam int FB_FRAC    = 8;
   localparam int PROD_FF_W  = COEF_W + SAMPLE_W;
   localparam int FF_W       = PROD_FF_W + 2;
   localparam int PROD_FB_W  = COEF_W + FB_W;
   localparam int ACC_W      = PROD_FB_W + 2;
   localparam int CSR_IDX_W  = 3;

   localparam logic [FB_W-1:0]     FB_MAX     = {1'b0, {(FB_W-1){1'b1}}};
   localparam logic [FB_W-1:0]     FB_MIN     = {1'b1, {(FB_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_ENABLE = 3'd0,
      CSR_COEF_B0       = 3'd1,
      CSR_COEF_B1       = 3'd2,
      CSR_COEF_B2       = 3'd3,
      CSR_COEF_A1       = 3'd4,
      CSR_COEF_A2       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                     enable;
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic                       valid;
      logic                       restart;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [FF_W-1:0]     ff;
   } ff_item_type;

endpackage
`default_nettype wire

[rtl/core/bqls_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_csr
// Enable bit and coefficient registers, written over the CSR channel.
// ----------------------------------------------------------------------------
module bqls_csr
   import bqls_pkg::*;
#(
   parameter int COEF_FRAC = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_data,
   output coef_set_type              coefs
);

   localparam logic [COEF_W-1:0] UNITY = COEF_W'(1) << COEF_FRAC;

   coef_set_type coefs_ff;
   coef_set_type coefs_in;

   assign csr_ready = 1'b1;
   assign coefs     = coefs_ff;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FILTER_ENABLE: coefs_in.enable = csr_data[0];
            CSR_COEF_B0:       coefs_in.b0     = csr_data;
            CSR_COEF_B1:       coefs_in.b1     = csr_data;
            CSR_COEF_B2:       coefs_in.b2     = csr_data;
            CSR_COEF_A1:       coefs_in.a1     = csr_data;
            CSR_COEF_A2:       coefs_in.a2     = csr_data;
            default:           coefs_in        = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.enable <= 1'b0;
         coefs_ff.b0     <= UNITY;
         coefs_ff.b1     <= '0;
         coefs_ff.b2     <= '0;
         coefs_ff.a1     <= '0;
         coefs_ff.a2     <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/bqls_ff.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_ff
// Input stage: input history and the feed-forward sum b0*x + b1*x1 + b2*x2.
// ----------------------------------------------------------------------------
module bqls_ff
   import bqls_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [SAMPLE_W-1:0] in_sample,
   input  wire logic                       in_restart,
   input  wire coef_set_type               coefs,
   input  wire logic                       down_ready,
   output ff_item_type                     item
);

   logic signed [SAMPLE_W-1:0]  xh1_ff, xh1_in;
   logic signed [SAMPLE_W-1:0]  xh2_ff, xh2_in;
   ff_item_type                 item_ff, item_in;
   logic signed [SAMPLE_W-1:0]  x_prev1, x_prev2;
   logic signed [PROD_FF_W-1:0] p0, p1, p2;
   logic signed [FF_W-1:0]      ff_sum;
   logic                        accept;

   assign item = item_ff;

   always_comb begin
      x_prev1  = in_restart ? '0 : xh1_ff;
      x_prev2  = in_restart ? '0 : xh2_ff;
      p0       = $signed(coefs.b0) * in_sample;
      p1       = $signed(coefs.b1) * x_prev1;
      p2       = $signed(coefs.b2) * x_prev2;
      ff_sum   = {{(FF_W-PROD_FF_W){p0[PROD_FF_W-1]}}, p0}
               + {{(FF_W-PROD_FF_W){p1[PROD_FF_W-1]}}, p1}
               + {{(FF_W-PROD_FF_W){p2[PROD_FF_W-1]}}, p2};
      in_ready = !item_ff.valid || down_ready;
      accept   = in_valid && in_ready;

      xh1_in  = xh1_ff;
      xh2_in  = xh2_ff;
      item_in = item_ff;
      if (accept) begin
         if (coefs.enable) begin
            xh2_in = x_prev1;
            xh1_in = in_sample;
         end else if (in_restart) begin
            xh2_in = '0;
            xh1_in = '0;
         end
         item_in.restart = in_restart;
         item_in.sample  = in_sample;
         item_in.ff      = ff_sum;
      end
      if (in_ready) begin
         item_in.valid = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xh1_ff  <= '0;
         xh2_ff  <= '0;
         item_ff <= '0;
      end else begin
         xh1_ff  <= xh1_in;
         xh2_ff  <= xh2_in;
         item_ff <= item_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_restart && !coefs.enable |=> xh1_ff == '0 && xh2_ff == '0)
      else $error("input history not cleared by restart while bypassed");
`endif

endmodule
`default_nettype wire

[rtl/core/bqls_fb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_fb
// Feedback stage: adds a1*y1 + a2*y2, truncates, saturates and registers
// the result and the Q24.8 output history, or passes the sample when disabled.
// ----------------------------------------------------------------------------
module bqls_fb
   import bqls_pkg::*;
#(
   parameter int COEF_FRAC = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ff_item_type          item,
   input  wire coef_set_type         coefs,
   output logic                      down_ready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]       rsp_tdata
);

   localparam int R_SHIFT = COEF_FRAC + FB_FRAC;

   logic signed [FB_W-1:0]      y1_ff, y1_in;
   logic signed [FB_W-1:0]      y2_ff, y2_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic signed [FB_W-1:0]      y1_base, y2_base;
   logic signed [PROD_FB_W-1:0] p1, p2;
   logic signed [ACC_W-1:0]     total, q_sh, r_sh;
   logic [ACC_W-1:0]            q_full, r_full;
   logic                        q_adj, r_adj;
   logic                        q_pos_ovf, q_neg_ovf, r_pos_ovf, r_neg_ovf;
   logic [FB_W-1:0]             y_sat;
   logic [SAMPLE_W-1:0]         r_sat;
   logic                        out_can, take;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign down_ready = out_can;

   always_comb begin
      out_can = !rsp_valid_ff || rsp_tready;
      take    = item.valid && out_can;
      y1_base = item.restart ? '0 : y1_ff;
      y2_base = item.restart ? '0 : y2_ff;
      p1      = $signed(coefs.a1) * y1_base;
      p2      = $signed(coefs.a2) * y2_base;
      total   = {{(ACC_W-FF_W-FB_FRAC){item.ff[FF_W-1]}}, item.ff, {FB_FRAC{1'b0}}}
              + {{(ACC_W-PROD_FB_W){p1[PROD_FB_W-1]}}, p1}
              + {{(ACC_W-PROD_FB_W){p2[PROD_FB_W-1]}}, p2};

      q_sh   = total >>> COEF_FRAC;
      q_adj  = total[ACC_W-1] && (|total[COEF_FRAC-1:0]);
      q_full = q_sh + {{(ACC_W-1){1'b0}}, q_adj};
      r_sh   = total >>> R_SHIFT;
      r_adj  = total[ACC_W-1] && (|total[R_SHIFT-1:0]);
      r_full = r_sh + {{(ACC_W-1){1'b0}}, r_adj};

      q_pos_ovf = !q_full[ACC_W-1] && (|q_full[ACC_W-1:FB_W-1]);
      q_neg_ovf = q_full[ACC_W-1] && !(&q_full[ACC_W-1:FB_W-1]);
      r_pos_ovf = !r_full[ACC_W-1] && (|r_full[ACC_W-1:SAMPLE_W-1]);
      r_neg_ovf = r_full[ACC_W-1] && !(&r_full[ACC_W-1:SAMPLE_W-1]);
      y_sat = q_pos_ovf ? FB_MAX : (q_neg_ovf ? FB_MIN : q_full[FB_W-1:0]);
      r_sat = r_pos_ovf ? SAMPLE_MAX : (r_neg_ovf ? SAMPLE_MIN : r_full[SAMPLE_W-1:0]);

      y1_in        = y1_ff;
      y2_in        = y2_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         if (coefs.enable) begin
            y2_in       = y1_base;
            y1_in       = y_sat;
            rsp_data_in = r_sat;
         end else begin
            if (item.restart) begin
               y2_in = '0;
               y1_in = '0;
            end
            rsp_data_in = item.sample;
         end
      end
      if (out_can) begin
         rsp_valid_in = item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      take && !coefs.enable |=> rsp_data_ff == $past(item.sample))
      else $error("bypassed sample does not reach the result register");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      take && coefs.enable |=> y2_ff == $past(y1_base))
      else $error("output history did not shift on a filtered transfer");
`endif

endmodule
`default_nettype wire

[rtl/core/biquad_low_shelf_saturating.sv]
// A sample passes the feed-forward item register and the result register
// before it appears on rsp_tvalid. Throughput: one sample per cycle while
// rsp_tready holds; the output stage's feedback multiply-add closes its loop
// combinationally, the feed-forward products one stage earlier. Synchronous
// active-high reset clears the history and the pipeline, disables the filter
// and sets b0 to unity, the other coefficients to zero.
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_low_shelf_saturating
// Direct-form-I low-shelf biquad on signed 16-bit PCM, saturating output.
// ----------------------------------------------------------------------------
module biquad_low_shelf_saturating
   import bqls_pkg::*;
#(
   parameter int COEF_FRAC = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [SAMPLE_W-1:0]  req_tdata,   // sample
   input  wire logic [0:0]           req_tuser,   // restart
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]       rsp_tdata,   // filtered
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_data
);

   coef_set_type coefs;
   ff_item_type  ff_item;
   logic         fb_ready;

   bqls_csr #(
      .COEF_FRAC (COEF_FRAC)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coefs     (coefs)
   );

   bqls_ff u_ff (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata),
      .in_restart (req_tuser[0]),
      .coefs      (coefs),
      .down_ready (fb_ready),
      .item       (ff_item)
   );

   bqls_fb #(
      .COEF_FRAC (COEF_FRAC)
   ) u_fb (
      .clock      (clock),
      .reset      (reset),
      .item       (ff_item),
      .coefs      (coefs),
      .down_ready (fb_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

[tb/sv/tb_biquad_low_shelf_saturating.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_low_shelf_saturating
// Self-checking bench for the low-shelf biquad with saturating output.
// Samples and coefficient settings are driven through the stream and register
// channels. A scoreboard keeps its own copy of the filter history and
// coefficients, computes each filtered sample with exact wide arithmetic and
// compares it with what the block returns. Directed cases cover pass-through,
// truncation, saturation of output and feedback, and restart; random phases
// follow, with random idling on both sides and long output stalls.
// ----------------------------------------------------------------------------
module tb_biquad_low_shelf_saturating;
   import bqls_pkg::*;

   localparam int COEF_FRAC   = 24;
   localparam int UNITY       = 1 << COEF_FRAC;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 160;

   class shelf_scoreboard;
      bit                         enable;
      logic signed [COEF_W-1:0]   b0, b1, b2, a1, a2;
      logic signed [SAMPLE_W-1:0] x1, x2;
      logic signed [FB_W-1:0]     y1, y2;
      logic signed [SAMPLE_W-1:0] filtered_due[$];
      int errors, checked, noted, restarts, clipped;

      function new();
         enable = 1'b0;
         b0 = UNITY;
         b1 = '0; b2 = '0; a1 = '0; a2 = '0;
         x1 = '0; x2 = '0; y1 = '0; y2 = '0;
         errors = 0; checked = 0; noted = 0; restarts = 0; clipped = 0;
      endfunction

      function void apply_setting(csr_index_type idx, logic [COEF_W-1:0] value);
         case (idx)
            CSR_FILTER_ENABLE: enable = value[0];
            CSR_COEF_B0:       b0 = value;
            CSR_COEF_B1:       b1 = value;
            CSR_COEF_B2:       b2 = value;
            CSR_COEF_A1:       a1 = value;
            CSR_COEF_A2:       a2 = value;
            default: ;
         endcase
      endfunction

      function logic signed [79:0] product(logic signed [79:0] c, logic signed [79:0] v);
         return c * v;
      endfunction

      function logic signed [SAMPLE_W-1:0] filter_step(logic signed [SAMPLE_W-1:0] x,
                                                        logic restart);
         logic signed [79:0] acc, q, r;
         if (restart) begin
            x1 = '0; x2 = '0; y1 = '0; y2 = '0;
         end
         if (!enable) return x;
         acc = product(b0, x) * 256 + product(b1, x1) * 256 + product(b2, x2) * 256
             + product(a1, y1) + product(a2, y2);
         // Both divisions truncate toward zero.
         q = acc >>> COEF_FRAC;
         if (acc < 0 && acc[COEF_FRAC-1:0] != '0) q = q + 1;
         x2 = x1;
         x1 = x;
         y2 = y1;
         if (q > $signed(FB_MAX)) y1 = FB_MAX;
         else if (q < $signed(FB_MIN)) y1 = FB_MIN;
         else y1 = q[FB_W-1:0];
         r = q >>> FB_FRAC;
         if (q < 0 && q[FB_FRAC-1:0] != '0) r = r + 1;
         if (r > $signed(SAMPLE_MAX)) begin
            clipped++;
            return SAMPLE_MAX;
         end
         if (r < $signed(SAMPLE_MIN)) begin
            clipped++;
            return SAMPLE_MIN;
         end
         return r[SAMPLE_W-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x, logic restart);
         noted++;
         if (restart) restarts++;
         filtered_due.push_back(filter_step(x, restart));
      endfunction

      function void check_filtered(logic signed [SAMPLE_W-1:0] actual);
         logic signed [SAMPLE_W-1:0] wanted;
         checked++;
         if (filtered_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected filtered sample %0d, nothing expected", $time, actual);
            return;
         end
         wanted = filtered_due.pop_front();
         if (actual !== wanted) begin
            errors++;
            $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, wanted, actual);
         end
      endfunction

      function int pending();
         return filtered_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [SAMPLE_W-1:0]   rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [COEF_W-1:0]     csr_data;

   shelf_scoreboard board;
   bit steady;
   int cycle_count;
   int phases_run;

   biquad_low_shelf_saturating #(
      .COEF_FRAC(COEF_FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_filtered($signed(rsp_tdata));
         if (csr_valid && csr_ready) board.apply_setting(csr_index, csr_data);
         if (req_tvalid && req_tready) board.note_sample($signed(req_tdata), req_tuser[0]);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, board.pending());
      $display("TEST FAILED");
      $finish;
   end

   initial begin : result_side
      int gap, held, taken;
      rsp_tready = 1'b0;
      taken = 0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (taken == 300 || taken == 1100) begin
            // A long stall lets the pipeline fill and push back on the input.
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
         end else begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic restart);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= x;
      req_tuser[0] <= restart;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (board.pending() != 0);
   endtask

   task automatic program_filter(input logic en, input logic [COEF_W-1:0] c0,
                                 input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                                 input logic [COEF_W-1:0] f1, input logic [COEF_W-1:0] f2);
      logic [COEF_W-1:0] vals[6];
      vals[0] = {{(COEF_W-1){1'b0}}, en};
      vals[1] = c0; vals[2] = c1; vals[3] = c2; vals[4] = f1; vals[5] = f2;
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      phases_run++;
   endtask

   function automatic logic [COEF_W-1:0] extreme_coef();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return UNITY;
         default: return -UNITY;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] near(input int base, input int span);
      return base + int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int kind;
      board = new();
      phases_run = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FILTER_ENABLE;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: filter off, samples pass through.
      send_sample(16'h0000, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0001, 1'b0);
      stop_sending();
      wait_drained();

      // Half-unity b0 exercises truncation toward zero on odd samples.
      program_filter(1'b1, UNITY / 2, UNITY, -UNITY, UNITY / 2, -(UNITY / 4));
      send_sample(-16'sd3, 1'b1);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd3, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(16'sd5, 1'b0);
      stop_sending();
      wait_drained();

      // Coefficients at their limits drive output and feedback into saturation.
      program_filter(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      stop_sending();
      wait_drained();

      // Large positive feedback grows until the kept value clips at 32 bits.
      program_filter(1'b1, UNITY, '0, '0, 32'h7FFF_FFFF, '0);
      send_sample(16'sd100, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      stop_sending();
      wait_drained();
      // A restart while bypassed must still clear the history.
      program_filter(1'b0, UNITY, '0, '0, 32'h7FFF_FFFF, '0);
      send_sample(-16'sd5, 1'b1);
      send_sample(16'sd7, 1'b0);
      stop_sending();
      wait_drained();
      program_filter(1'b1, UNITY, '0, '0, 32'h7FFF_FFFF, '0);
      send_sample(16'sd1000, 1'b0);
      send_sample(16'sd2000, 1'b0);
      stop_sending();
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) kind = 0;
         else if (p == 1) kind = 2;
         else if (p == 2) kind = 3;
         else kind = $urandom_range(0, 5);
         case (kind)
            1: program_filter(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
            2: program_filter(1'b1, extreme_coef(), extreme_coef(), extreme_coef(),
                              extreme_coef(), extreme_coef());
            3: program_filter(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: program_filter(1'b1, near(18454938, 1 << 20), near(-28521267, 1 << 20),
                                    near(12582912, 1 << 20), near(30198989, 1 << 18),
                                    near(-13589545, 1 << 18));
         endcase
         steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 40) begin
               stop_sending();
               wait_drained();
            end
            send_sample(draw_sample(), $urandom_range(0, 15) == 0);
         end
         stop_sending();
         wait_drained();
         steady = 1'b0;
      end

      repeat (10) @(negedge clock);
      if (board.pending() != 0) begin
         board.errors++;
         $display("%0t: %0d filtered samples never arrived, next expected %0d",
                  $time, board.pending(), board.filtered_due[0]);
      end
      $display("Checked %0d of %0d samples over %0d settings, %0d restarts, %0d clipped",
               board.checked, board.noted, phases_run, board.restarts, board.clipped);
      $display("Mismatches: %0d, cycles: %0d", board.errors, cycle_count);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
